@@ hw/rtl/dfdt_pkg.sv @@
// ----------------------------------------------------------------------------
// dfdt_pkg: shared types and constants for the double to decimal text block
// Holds the queue entry layout, the item kinds, ASCII codes and sizing.
// ----------------------------------------------------------------------------
package dfdt_pkg;

    // Largest number of digits printed after the decimal point.
    localparam int MAX_FRACTION_DIGITS = 9;
    localparam logic [3:0] FRAC_DIGITS_RESET = 4'd6;

    // Width of the working significand and of the binary scale exponent.
    localparam int XW = 86;
    localparam int KW = 7;
    localparam logic [KW-1:0] K_MAX = 7'd85;

    // Saturation value of the integer part (2^31 - 1).
    localparam logic [30:0] INT_PART_MAX = 31'h7FFF_FFFF;

    // ASCII codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_F     = 8'h66;

    typedef enum logic [1:0] {
        KIND_NUM,
        KIND_INF,
        KIND_NAN
    } kind_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        kind_t        kind;
        logic         neg;
        logic [3:0]   digits;
        logic         sat;
        logic [30:0]  whole;
        logic [52:0]  frac;
        logic [KW-1:0] k;
    } item_t;

endpackage

@@ hw/rtl/double_to_fixed_decimal_text.sv @@
// ----------------------------------------------------------------------------
// double_to_fixed_decimal_text: binary64 to fixed-point decimal text
// Prints one double per item as ASCII characters, one per transfer.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_value_bits[63:0]      | in
//  result  | m_valid m_ready m_char_code m_last_char | out
//  config  | cfg_valid cfg_ready cfg_data[3:0]       | in
//
// A finite value passes through the multiply, normalize, round, add-half,
// second normalize and round, extract, carry, BCD and emit states; NaN and
// infinity go straight from idle to the emit state and print their characters.
// Reset sets fraction_digits to 6 and empties the front stage and queue.
// The front and a two-entry queue keep accepting while the back stalls on
// m_ready; the result register holds its character until it is taken.
// ----------------------------------------------------------------------------
module double_to_fixed_decimal_text import dfdt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_code,
    output logic        m_last_char,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    logic [3:0] fraction_digits_reg;
    logic       f_valid, f_ready;
    item_t      f_item;
    logic       q_valid, q_ready;
    item_t      q_item;

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fraction_digits_reg <= FRAC_DIGITS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            fraction_digits_reg <= cfg_data;
        end
    end

    dfdt_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value_bits    (s_value_bits),
        .fraction_digits (fraction_digits_reg),
        .item_valid      (f_valid),
        .item            (f_item),
        .item_ready      (f_ready)
    );

    dfdt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    dfdt_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_item     (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last_char (m_last_char)
    );

    // The result register is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The decimal point is never the final character.
    a_dot_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_code == CH_DOT |-> !m_last_char)
        else $error("text ends on the decimal point");

    // Text ends on a digit or on the last letter of nan or inf.
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_char |->
            (m_char_code >= CH_ZERO && m_char_code <= 8'h39) ||
            m_char_code == CH_N || m_char_code == CH_F)
        else $error("unexpected final character");

endmodule

@@ hw/rtl/dfdt_front.sv @@
// ----------------------------------------------------------------------------
// dfdt_front: input stage and classifier
// Accepts a binary64 pattern, sorts out NaN and infinity, and splits a
// finite value into its integer part and its binary fraction.
// ----------------------------------------------------------------------------
module dfdt_front import dfdt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value_bits,
    input  logic [3:0]  fraction_digits,
    output logic        item_valid,
    output item_t       item,
    input  logic        item_ready
);

    logic        item_valid_reg;
    item_t       item_reg;

    logic [10:0] expo;
    logic [51:0] mant;
    logic [63:0] m64;
    logic [11:0] sh;
    logic [63:0] whole_full;
    logic [63:0] frac_full;
    item_t       cls;

    // Classify the incoming pattern.
    always_comb begin
        expo       = s_value_bits[62:52];
        mant       = s_value_bits[51:0];
        m64        = {11'd0, (expo != 11'd0), mant};
        sh         = (expo == 11'd0) ? 12'd1074 : (12'd1075 - {1'b0, expo});
        whole_full = m64 >> sh[5:0];
        frac_full  = m64 & ~(64'hFFFF_FFFF_FFFF_FFFF << sh[5:0]);
        cls        = '0;
        cls.kind   = KIND_NUM;
        cls.neg    = s_value_bits[63];
        cls.k      = 7'd1;
        if (fraction_digits == 4'd0) begin
            cls.digits = 4'd1;
        end else if (fraction_digits > 4'(MAX_FRACTION_DIGITS)) begin
            cls.digits = 4'(MAX_FRACTION_DIGITS);
        end else begin
            cls.digits = fraction_digits;
        end
        if (expo == 11'h7FF) begin
            cls.kind = (mant != 52'd0) ? KIND_NAN : KIND_INF;
        end else if (expo >= 11'd1075) begin
            // No fraction bits left; the integer part is far above 2^31.
            cls.sat = 1'b1;
        end else if (sh >= 12'd53) begin
            // Pure fraction. Beyond 2^-85 it cannot reach one half.
            if (sh > {5'd0, K_MAX}) begin
                cls.k = K_MAX;
            end else begin
                cls.frac = m64[52:0];
                cls.k    = sh[6:0];
            end
        end else begin
            cls.sat   = |whole_full[63:31];
            cls.whole = whole_full[30:0];
            cls.frac  = frac_full[52:0];
            cls.k     = sh[6:0];
        end
    end

    assign s_ready    = !item_valid_reg || item_ready;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    // Output register toward the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            item_valid_reg <= 1'b1;
        end else if (item_ready) begin
            item_valid_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            item_reg <= cls;
        end
    end

endmodule

@@ hw/rtl/dfdt_queue.sv @@
// ----------------------------------------------------------------------------
// dfdt_queue: two-entry queue between the front and the back
// Lets the front keep taking items while the back is busy printing.
// ----------------------------------------------------------------------------
module dfdt_queue import dfdt_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ hw/rtl/dfdt_back.sv @@
// ----------------------------------------------------------------------------
// dfdt_back: fraction rounding, decimal conversion and character output
// Scales the fraction by 10^p, repeats the two double roundings of
// frac*10^p + 0.5, converts both parts to BCD and sends the text.
// ----------------------------------------------------------------------------
module dfdt_back import dfdt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  item_t      in_item,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_code,
    output logic       m_last_char
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_NORM,
        ST_ROUND,
        ST_ADD,
        ST_EXTR,
        ST_CARRY,
        ST_BCD,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        E_START,
        E_SIGN,
        E_TXT,
        E_INT,
        E_DOT,
        E_FRAC
    } emit_t;

    // Four double-dabble steps: adjust each digit, then shift one bit in.
    function automatic logic [39:0] dd4(input logic [39:0] b, input logic [3:0] n);
        logic [39:0] t;
        t = b;
        for (int s = 3; s >= 0; s--) begin
            for (int d = 0; d < 10; d++) begin
                if (t[d*4 +: 4] >= 4'd5) begin
                    t[d*4 +: 4] = t[d*4 +: 4] + 4'd3;
                end
            end
            t = {t[38:0], n[s]};
        end
        return t;
    endfunction

    function automatic logic [29:0] pow10(input logic [3:0] p);
        logic [29:0] r;
        case (p)
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = 30'd1;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] spec_char(input kind_t kind, input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = (kind == KIND_NAN) ? CH_N : CH_I;
            4'd1:    c = (kind == KIND_NAN) ? CH_A : CH_N;
            default: c = (kind == KIND_NAN) ? CH_N : CH_F;
        endcase
        return c;
    endfunction

    state_t        state_reg, state_next;
    emit_t         emit_reg, emit_next;
    item_t         item_reg, item_next;
    logic [XW-1:0] x_reg, x_next;
    logic          g_reg, g_next;
    logic          s_reg, s_next;
    logic [KW-1:0] k_reg, k_next;
    logic          phase_reg, phase_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [29:0]   dec_reg, dec_next;
    logic [31:0]   whole_sh_reg, whole_sh_next;
    logic [31:0]   frac_sh_reg, frac_sh_next;
    logic [39:0]   bcd_int_reg, bcd_int_next;
    logic [39:0]   bcd_frac_reg, bcd_frac_next;
    logic [3:0]    idx_reg, idx_next;
    logic          mvalid_reg, mvalid_next;
    logic [7:0]    char_reg, char_next;
    logic          last_reg, last_next;

    logic          out_free;
    logic [XW-1:0] x_shr;
    logic [31:0]   wsum;
    logic          carry;
    logic [3:0]    msd;

    assign in_ready    = (state_reg == ST_IDLE);
    assign m_valid     = mvalid_reg;
    assign m_char_code = char_reg;
    assign m_last_char = last_reg;
    assign out_free    = !mvalid_reg || m_ready;

    // Highest nonzero digit of the integer part (zero prints one digit).
    always_comb begin
        msd = 4'd0;
        for (int d = 0; d < 10; d++) begin
            if (bcd_int_reg[d*4 +: 4] != 4'd0) begin
                msd = 4'(d);
            end
        end
    end

    // Next-state logic of the sequencer and the output register.
    always_comb begin
        state_next    = state_reg;
        emit_next     = emit_reg;
        item_next     = item_reg;
        x_next        = x_reg;
        g_next        = g_reg;
        s_next        = s_reg;
        k_next        = k_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        dec_next      = dec_reg;
        whole_sh_next = whole_sh_reg;
        frac_sh_next  = frac_sh_reg;
        bcd_int_next  = bcd_int_reg;
        bcd_frac_next = bcd_frac_reg;
        idx_next      = idx_reg;
        mvalid_next   = mvalid_reg && !m_ready;
        char_next     = char_reg;
        last_next     = last_reg;
        x_shr         = x_reg >> k_reg;
        carry         = (dec_reg >= pow10(item_reg.digits));
        wsum          = {1'b0, item_reg.whole} + {31'd0, carry};

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    item_next  = in_item;
                    x_next     = {33'd0, in_item.frac};
                    k_next     = in_item.k;
                    g_next     = 1'b0;
                    s_next     = 1'b0;
                    phase_next = 1'b0;
                    cnt_next   = in_item.digits;
                    emit_next  = E_START;
                    state_next = (in_item.kind == KIND_NUM) ? ST_MUL : ST_EMIT;
                end
            end
            ST_MUL: begin
                // Exact fraction times ten, once per digit.
                if (cnt_reg == 4'd0) begin
                    state_next = ST_NORM;
                end else begin
                    x_next   = (x_reg << 3) + (x_reg << 1);
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            ST_NORM: begin
                // Bring the significand under 2^53, keeping guard and sticky.
                if (|x_reg[XW-1:61]) begin
                    x_next = x_reg >> 8;
                    g_next = x_reg[7];
                    s_next = (|x_reg[6:0]) | g_reg | s_reg;
                    k_next = k_reg - 7'd8;
                end else if (|x_reg[XW-1:53]) begin
                    x_next = x_reg >> 1;
                    g_next = x_reg[0];
                    s_next = g_reg | s_reg;
                    k_next = k_reg - 7'd1;
                end else begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                // Round to nearest, ties to even.
                if (g_reg && (s_reg || x_reg[0])) begin
                    x_next = x_reg + {{(XW-1){1'b0}}, 1'b1};
                end
                g_next     = 1'b0;
                s_next     = 1'b0;
                state_next = phase_reg ? ST_EXTR : ST_ADD;
            end
            ST_ADD: begin
                // Add one half at the current binary scale.
                x_next     = x_reg + ({{(XW-1){1'b0}}, 1'b1} << (k_reg - 7'd1));
                phase_next = 1'b1;
                state_next = ST_NORM;
            end
            ST_EXTR: begin
                dec_next   = x_shr[29:0];
                state_next = ST_CARRY;
            end
            ST_CARRY: begin
                // A fraction that reached 10^p carries into the integer part.
                if (carry) begin
                    dec_next = 30'd0;
                end
                if (item_reg.sat || wsum[31]) begin
                    whole_sh_next = {1'b0, INT_PART_MAX};
                end else begin
                    whole_sh_next = wsum;
                end
                frac_sh_next  = carry ? 32'd0 : {2'b00, dec_reg};
                bcd_int_next  = 40'd0;
                bcd_frac_next = 40'd0;
                cnt_next      = 4'd8;
                state_next    = ST_BCD;
            end
            ST_BCD: begin
                bcd_int_next  = dd4(bcd_int_reg, whole_sh_reg[31:28]);
                bcd_frac_next = dd4(bcd_frac_reg, frac_sh_reg[31:28]);
                whole_sh_next = whole_sh_reg << 4;
                frac_sh_next  = frac_sh_reg << 4;
                cnt_next      = cnt_reg - 4'd1;
                if (cnt_reg == 4'd1) begin
                    emit_next  = E_START;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_reg == E_START) begin
                    if (item_reg.neg && item_reg.kind != KIND_NAN) begin
                        emit_next = E_SIGN;
                    end else if (item_reg.kind != KIND_NUM) begin
                        emit_next = E_TXT;
                        idx_next  = 4'd0;
                    end else begin
                        emit_next = E_INT;
                        idx_next  = msd;
                    end
                end else if (out_free) begin
                    mvalid_next = 1'b1;
                    last_next   = 1'b0;
                    case (emit_reg)
                        E_SIGN: begin
                            char_next = CH_MINUS;
                            if (item_reg.kind != KIND_NUM) begin
                                emit_next = E_TXT;
                                idx_next  = 4'd0;
                            end else begin
                                emit_next = E_INT;
                                idx_next  = msd;
                            end
                        end
                        E_TXT: begin
                            char_next = spec_char(item_reg.kind, idx_reg);
                            idx_next  = idx_reg + 4'd1;
                            if (idx_reg == 4'd2) begin
                                last_next  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        E_INT: begin
                            char_next = CH_ZERO + {4'd0, bcd_int_reg[{idx_reg, 2'b00} +: 4]};
                            if (idx_reg == 4'd0) begin
                                emit_next = E_DOT;
                            end else begin
                                idx_next = idx_reg - 4'd1;
                            end
                        end
                        E_DOT: begin
                            char_next = CH_DOT;
                            emit_next = E_FRAC;
                            idx_next  = item_reg.digits - 4'd1;
                        end
                        default: begin
                            char_next = CH_ZERO + {4'd0, bcd_frac_reg[{idx_reg, 2'b00} +: 4]};
                            idx_next  = idx_reg - 4'd1;
                            if (idx_reg == 4'd0) begin
                                last_next  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            emit_reg   <= E_START;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            emit_reg   <= emit_next;
            mvalid_reg <= mvalid_next;
        end
        item_reg     <= item_next;
        x_reg        <= x_next;
        g_reg        <= g_next;
        s_reg        <= s_next;
        k_reg        <= k_next;
        phase_reg    <= phase_next;
        cnt_reg      <= cnt_next;
        dec_reg      <= dec_next;
        whole_sh_reg <= whole_sh_next;
        frac_sh_reg  <= frac_sh_next;
        bcd_int_reg  <= bcd_int_next;
        bcd_frac_reg <= bcd_frac_next;
        idx_reg      <= idx_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
    end

endmodule
